// File: design/bsfq_pkg.sv
package bsfq_pkg;

  localparam int THERMISTOR_COUNT = 5;
  localparam int SLAVE_COUNT      = 4;
  localparam int PARALLEL_STRINGS = 1;

  localparam logic [15:0] FULL_SCALE_16 = 16'hFFFF;

  localparam int TEMP_SUM_W  = 21;
  localparam int STACK_SUM_W = 18;
  localparam int COUNT_W     = 7;
  localparam int FAULT_W     = 3;

  localparam logic [TEMP_SUM_W-1:0]  TEMP_SUM_MAX  = '1;
  localparam logic [STACK_SUM_W-1:0] STACK_SUM_MAX = '1;

  // register indexes on the write port
  localparam logic [1:0] REG_OVER_VOLTAGE  = 2'd0;
  localparam logic [1:0] REG_UNDER_VOLTAGE = 2'd1;
  localparam logic [1:0] REG_OVER_TEMP     = 2'd2;
  localparam logic [1:0] REG_RETRY         = 2'd3;

  // fault bit positions
  localparam int FAULT_OV = 0;
  localparam int FAULT_UV = 1;
  localparam int FAULT_OT = 2;

  localparam logic [15:0]        OV_LIMIT_RESET    = 16'hFFFF;
  localparam logic [15:0]        UV_LIMIT_RESET    = 16'h0000;
  localparam logic [15:0]        OT_LIMIT_RESET    = 16'hFFFF;
  localparam logic [COUNT_W-1:0] RETRY_LIMIT_RESET = 7'd10;

  // average: floor(n / d) = (n * ceil(2^k / d)) >> k, exact for n < 2^21 with d <= 128
  localparam int AVG_DIVISOR = SLAVE_COUNT * THERMISTOR_COUNT;
  localparam int AVG_SHIFT   = TEMP_SUM_W + 7;
  localparam logic [AVG_SHIFT:0] AVG_RECIP =
    (AVG_SHIFT+1)'(((64'd1 << AVG_SHIFT) + AVG_DIVISOR - 1) / AVG_DIVISOR);

  localparam int TRAC_SHIFT = STACK_SUM_W + 2;
  localparam logic [TRAC_SHIFT:0] TRAC_RECIP =
    (TRAC_SHIFT+1)'(((64'd1 << TRAC_SHIFT) + PARALLEL_STRINGS - 1) / PARALLEL_STRINGS);

  typedef struct packed {
    logic [15:0]        ov_limit;
    logic [15:0]        uv_limit;
    logic [15:0]        ot_limit;
    logic [COUNT_W-1:0] retry_limit;
  } limits_t;

  typedef struct packed {
    logic [15:0]            max_voltage;
    logic [15:0]            min_voltage;
    logic [15:0]            max_temp;
    logic [TEMP_SUM_W-1:0]  temp_sum;
    logic [STACK_SUM_W-1:0] stack_sum;
    logic [FAULT_W-1:0]     faults;
  } totals_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               latch;
  } cnt_step_t;

  // step up on a crossing, down otherwise, clamp to 0 .. limit
  function automatic cnt_step_t step_counter(input logic [COUNT_W-1:0] count,
                                             input logic               crossed,
                                             input logic [COUNT_W-1:0] limit);
    cnt_step_t        res;
    logic [COUNT_W:0] stepped;
    logic             below;
    below   = !crossed && (count == '0);
    stepped = crossed ? ({1'b0, count} + 1'b1) : ({1'b0, count} - 1'b1);
    res     = '0;
    if (!below && (stepped >= {1'b0, limit})) begin
      res.count = limit;
      res.latch = 1'b1;
    end else if (below) begin
      res.count = '0;
    end else begin
      res.count = stepped[COUNT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/bsfq_scan_acc.sv
module bsfq_scan_acc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           slave_min_voltage,
  input  logic [15:0]           slave_max_voltage,
  input  logic [15:0]           temp_reading_0,
  input  logic [15:0]           temp_reading_1,
  input  logic [15:0]           temp_reading_2,
  input  logic [15:0]           temp_reading_3,
  input  logic [15:0]           temp_reading_4,
  input  logic [15:0]           stack_voltage,
  input  logic                  last_slave,
  input  bsfq_pkg::limits_t     limits,
  output logic                  scan_valid,
  output bsfq_pkg::totals_t     scan_totals,
  input  logic                  scan_take
);
  import bsfq_pkg::*;

  // input register
  logic        s1_valid;
  logic [15:0] s1_vmin;
  logic [15:0] s1_vmax;
  logic [15:0] s1_temp [THERMISTOR_COUNT];
  logic [15:0] s1_stack;
  logic        s1_last;

  // running scan state
  logic [15:0]            run_min_voltage;
  logic [15:0]            run_max_voltage;
  logic [15:0]            run_max_temp;
  logic [TEMP_SUM_W-1:0]  temp_sum;
  logic [STACK_SUM_W-1:0] stack_sum;
  logic [COUNT_W-1:0]     fault_counters [FAULT_W];
  logic [FAULT_W-1:0]     latched_faults;

  logic                   scan_free;
  logic                   s1_leave;
  logic                   fire;
  logic                   close;

  logic [15:0]            min_next;
  logic [15:0]            max_next;
  logic [15:0]            temp_max_next;
  logic [TEMP_SUM_W:0]    temp_sum_wide;
  logic [TEMP_SUM_W-1:0]  temp_sum_next;
  logic [STACK_SUM_W:0]   stack_sum_wide;
  logic [STACK_SUM_W-1:0] stack_sum_next;
  logic [FAULT_W-1:0]     crossed;
  cnt_step_t              steps [FAULT_W];
  logic [FAULT_W-1:0]     latched_next;

  assign scan_free = !scan_valid || scan_take;
  // a closing request waits here until the totals register is free
  assign s1_leave  = !s1_last || scan_free;
  assign in_stall  = s1_valid && !s1_leave;
  assign fire      = s1_valid && s1_leave;
  assign close     = fire && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_vmin    <= slave_min_voltage;
      s1_vmax    <= slave_max_voltage;
      s1_temp[0] <= temp_reading_0;
      s1_temp[1] <= temp_reading_1;
      s1_temp[2] <= temp_reading_2;
      s1_temp[3] <= temp_reading_3;
      s1_temp[4] <= temp_reading_4;
      s1_stack   <= stack_voltage;
      s1_last    <= last_slave;
    end
  end

  always_comb begin
    logic [TEMP_SUM_W:0] add;
    add           = '0;
    temp_max_next = run_max_temp;
    for (int j = 0; j < THERMISTOR_COUNT; j++) begin
      if (s1_temp[j] > temp_max_next) begin
        temp_max_next = s1_temp[j];
      end
      add = add + (TEMP_SUM_W+1)'(s1_temp[j]);
    end
    // readings are never negative, so one clamp at the end equals a clamp per step
    temp_sum_wide = {1'b0, temp_sum} + add;
    temp_sum_next = temp_sum_wide[TEMP_SUM_W] ? TEMP_SUM_MAX : temp_sum_wide[TEMP_SUM_W-1:0];
  end

  assign min_next       = (s1_vmin < run_min_voltage) ? s1_vmin : run_min_voltage;
  assign max_next       = (s1_vmax > run_max_voltage) ? s1_vmax : run_max_voltage;
  assign stack_sum_wide = {1'b0, stack_sum} + (STACK_SUM_W+1)'(s1_stack);
  assign stack_sum_next = stack_sum_wide[STACK_SUM_W] ? STACK_SUM_MAX
                                                      : stack_sum_wide[STACK_SUM_W-1:0];

  assign crossed[FAULT_OV] = max_next > limits.ov_limit;
  assign crossed[FAULT_UV] = min_next < limits.uv_limit;
  assign crossed[FAULT_OT] = temp_max_next > limits.ot_limit;

  always_comb begin
    latched_next = latched_faults;
    for (int i = 0; i < FAULT_W; i++) begin
      steps[i] = step_counter(fault_counters[i], crossed[i], limits.retry_limit);
      if (steps[i].latch) begin
        latched_next[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_voltage <= FULL_SCALE_16;
      run_max_voltage <= '0;
      run_max_temp    <= '0;
      temp_sum        <= '0;
      stack_sum       <= '0;
      latched_faults  <= '0;
      for (int i = 0; i < FAULT_W; i++) begin
        fault_counters[i] <= '0;
      end
    end else if (close) begin
      run_min_voltage <= FULL_SCALE_16;
      run_max_voltage <= '0;
      run_max_temp    <= '0;
      temp_sum        <= '0;
      stack_sum       <= '0;
      latched_faults  <= latched_next;
      for (int i = 0; i < FAULT_W; i++) begin
        fault_counters[i] <= steps[i].count;
      end
    end else if (fire) begin
      run_min_voltage <= min_next;
      run_max_voltage <= max_next;
      run_max_temp    <= temp_max_next;
      temp_sum        <= temp_sum_next;
      stack_sum       <= stack_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (scan_free) begin
      scan_valid <= close;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      scan_totals.max_voltage <= max_next;
      scan_totals.min_voltage <= min_next;
      scan_totals.max_temp    <= temp_max_next;
      scan_totals.temp_sum    <= temp_sum_next;
      scan_totals.stack_sum   <= stack_sum_next;
      scan_totals.faults      <= latched_next;
    end
  end

  a_faults_stay_latched: assert property (@(posedge clk) disable iff (rst)
    (latched_faults & $past(latched_faults)) == $past(latched_faults))
    else $error("latched fault bit cleared without reset");

  a_stall_only_on_close: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && scan_valid))
    else $error("input stalled without a waiting scan close");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    (scan_valid && !scan_take) |=> (scan_valid && $stable(scan_totals)))
    else $error("scan totals lost before being taken");

endmodule

// File: design/bsfq_result.sv
module bsfq_result (
  input  logic              clk,
  input  logic              rst,
  input  logic              scan_valid,
  input  bsfq_pkg::totals_t scan_totals,
  output logic              scan_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       pack_max_voltage,
  output logic [15:0]       pack_min_voltage,
  output logic [15:0]       voltage_spread,
  output logic [15:0]       pack_max_temp,
  output logic [15:0]       pack_avg_temp,
  output logic [17:0]       tractive_voltage,
  output logic [2:0]        fault_bits,
  output logic              shutdown
);
  import bsfq_pkg::*;

  localparam int AVG_PROD_W  = TEMP_SUM_W + AVG_SHIFT;
  localparam int TRAC_PROD_W = STACK_SUM_W + TRAC_SHIFT;

  logic                         out_free;
  logic                         s3_free;
  logic [AVG_PROD_W-1:0]        avg_prod;
  logic [TRAC_PROD_W-1:0]       trac_prod;

  logic                         s3_valid;
  logic [15:0]                  s3_max_v;
  logic [15:0]                  s3_min_v;
  logic [15:0]                  s3_max_t;
  logic [TEMP_SUM_W-1:0]        s3_avg;
  logic [STACK_SUM_W-1:0]       s3_trac;
  logic [FAULT_W-1:0]           s3_faults;

  assign out_free  = !out_valid || !out_stall;
  assign s3_free   = !s3_valid || out_free;
  assign scan_take = s3_free;

  // reciprocal multiplies stand in for the constant divides
  assign avg_prod  = AVG_PROD_W'(scan_totals.temp_sum) * AVG_PROD_W'(AVG_RECIP);
  assign trac_prod = TRAC_PROD_W'(scan_totals.stack_sum) * TRAC_PROD_W'(TRAC_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && s3_free) begin
      s3_max_v  <= scan_totals.max_voltage;
      s3_min_v  <= scan_totals.min_voltage;
      s3_max_t  <= scan_totals.max_temp;
      s3_avg    <= avg_prod[AVG_PROD_W-1:AVG_SHIFT];
      s3_trac   <= trac_prod[TRAC_PROD_W-1:TRAC_SHIFT];
      s3_faults <= scan_totals.faults;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && out_free) begin
      pack_max_voltage <= s3_max_v;
      pack_min_voltage <= s3_min_v;
      voltage_spread   <= s3_max_v - s3_min_v;
      pack_max_temp    <= s3_max_t;
      pack_avg_temp    <= (s3_avg > TEMP_SUM_W'(FULL_SCALE_16)) ? FULL_SCALE_16 : s3_avg[15:0];
      tractive_voltage <= s3_trac;
      fault_bits       <= s3_faults;
      shutdown         <= |s3_faults;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !out_free) |=> s3_valid)
    else $error("quotient stage dropped while output stalled");

  a_shutdown_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shutdown == (fault_bits != '0)))
    else $error("shutdown disagrees with fault bits");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_valid))
    else $error("result appeared without a quotient stage entry");

endmodule

// File: design/battery_scan_fault_qualifier.sv
// battery scan fault qualifier
// input channel: one request per monitor slave (cell min/max, five thermistor
// readings, stack voltage, last_slave). accepted when in_valid is high and
// in_stall is low. one request can be taken every cycle.
// a request with last_slave set closes the scan; it gives one result on the
// output channel (out_valid / out_stall), other requests give none.
// a closing request passes the input register, accumulate/fault-count stage,
// reciprocal multiply stage and output register before out_valid rises.
// throughput is one request per cycle while in_stall is low. when the receiver
// stalls, up to three results are held in the pipe; only a closing request then
// waits in the input register, so in_stall rises only when a closing request
// meets a full pipe. non-closing requests keep flowing. the limit registers are
// written through wr_en / wr_index / wr_data, by the user only while idle; the
// block does not enforce it. reset (rst, synchronous) restores the limit defaults,
// clears the running scan, the fault counters, the latched faults and all valid flags.
module battery_scan_fault_qualifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] slave_min_voltage,
  input  logic [15:0] slave_max_voltage,
  input  logic [15:0] temp_reading_0,
  input  logic [15:0] temp_reading_1,
  input  logic [15:0] temp_reading_2,
  input  logic [15:0] temp_reading_3,
  input  logic [15:0] temp_reading_4,
  input  logic [15:0] stack_voltage,
  input  logic        last_slave,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pack_max_voltage,
  output logic [15:0] pack_min_voltage,
  output logic [15:0] voltage_spread,
  output logic [15:0] pack_max_temp,
  output logic [15:0] pack_avg_temp,
  output logic [17:0] tractive_voltage,
  output logic [2:0]  fault_bits,
  output logic        shutdown
);
  import bsfq_pkg::*;

  limits_t limits;
  logic    scan_valid;
  totals_t scan_totals;
  logic    scan_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.ov_limit    <= OV_LIMIT_RESET;
      limits.uv_limit    <= UV_LIMIT_RESET;
      limits.ot_limit    <= OT_LIMIT_RESET;
      limits.retry_limit <= RETRY_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OVER_VOLTAGE:  limits.ov_limit    <= wr_data;
        REG_UNDER_VOLTAGE: limits.uv_limit    <= wr_data;
        REG_OVER_TEMP:     limits.ot_limit    <= wr_data;
        REG_RETRY:         limits.retry_limit <= wr_data[COUNT_W-1:0];
        default:           limits             <= limits;
      endcase
    end
  end

  bsfq_scan_acc u_scan_acc (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .slave_min_voltage (slave_min_voltage),
    .slave_max_voltage (slave_max_voltage),
    .temp_reading_0    (temp_reading_0),
    .temp_reading_1    (temp_reading_1),
    .temp_reading_2    (temp_reading_2),
    .temp_reading_3    (temp_reading_3),
    .temp_reading_4    (temp_reading_4),
    .stack_voltage     (stack_voltage),
    .last_slave        (last_slave),
    .limits            (limits),
    .scan_valid        (scan_valid),
    .scan_totals       (scan_totals),
    .scan_take         (scan_take)
  );

  bsfq_result u_result (
    .clk              (clk),
    .rst              (rst),
    .scan_valid       (scan_valid),
    .scan_totals      (scan_totals),
    .scan_take        (scan_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pack_max_voltage (pack_max_voltage),
    .pack_min_voltage (pack_min_voltage),
    .voltage_spread   (voltage_spread),
    .pack_max_temp    (pack_max_temp),
    .pack_avg_temp    (pack_avg_temp),
    .tractive_voltage (tractive_voltage),
    .fault_bits       (fault_bits),
    .shutdown         (shutdown)
  );

endmodule

// File: tb/tb_battery_scan_fault_qualifier.sv
`timescale 1ns / 1ps

module tb_battery_scan_fault_qualifier;
  import bsfq_pkg::*;

  typedef struct packed {
    logic [15:0]                       cell_min;
    logic [15:0]                       cell_max;
    logic [THERMISTOR_COUNT-1:0][15:0] temps;
    logic [15:0]                       stack;
    logic                              last;
  } slave_report_t;

  typedef struct packed {
    logic [15:0]        max_v;
    logic [15:0]        min_v;
    logic [15:0]        spread;
    logic [15:0]        max_t;
    logic [15:0]        avg_t;
    logic [17:0]        trac;
    logic [FAULT_W-1:0] faults;
    logic               shutdown;
  } scan_summary_t;

  typedef enum {CELLS_NOMINAL, CELLS_ANY, CELLS_EXTREME} report_style_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] slave_min_voltage;
  logic [15:0] slave_max_voltage;
  logic [15:0] temp_reading_0;
  logic [15:0] temp_reading_1;
  logic [15:0] temp_reading_2;
  logic [15:0] temp_reading_3;
  logic [15:0] temp_reading_4;
  logic [15:0] stack_voltage;
  logic        last_slave;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] pack_max_voltage;
  logic [15:0] pack_min_voltage;
  logic [15:0] voltage_spread;
  logic [15:0] pack_max_temp;
  logic [15:0] pack_avg_temp;
  logic [17:0] tractive_voltage;
  logic [2:0]  fault_bits;
  logic        shutdown;

  battery_scan_fault_qualifier dut (
    .clk               (clk),
    .rst               (rst),
    .wr_en             (wr_en),
    .wr_index          (wr_index),
    .wr_data           (wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .slave_min_voltage (slave_min_voltage),
    .slave_max_voltage (slave_max_voltage),
    .temp_reading_0    (temp_reading_0),
    .temp_reading_1    (temp_reading_1),
    .temp_reading_2    (temp_reading_2),
    .temp_reading_3    (temp_reading_3),
    .temp_reading_4    (temp_reading_4),
    .stack_voltage     (stack_voltage),
    .last_slave        (last_slave),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pack_max_voltage  (pack_max_voltage),
    .pack_min_voltage  (pack_min_voltage),
    .voltage_spread    (voltage_spread),
    .pack_max_temp     (pack_max_temp),
    .pack_avg_temp     (pack_avg_temp),
    .tractive_voltage  (tractive_voltage),
    .fault_bits        (fault_bits),
    .shutdown          (shutdown)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // requests waiting for the driver, summaries waiting for the output side
  slave_report_t queued_reports[$];
  scan_summary_t pending_summaries[$];

  // predictor state
  logic [15:0]            acc_min_v;
  logic [15:0]            acc_max_v;
  logic [15:0]            acc_max_t;
  logic [TEMP_SUM_W-1:0]  acc_temp_sum;
  logic [STACK_SUM_W-1:0] acc_stack_sum;
  int                     fault_count[FAULT_W];
  logic [FAULT_W-1:0]     fault_latch;
  logic [15:0]            lim_ov;
  logic [15:0]            lim_uv;
  logic [15:0]            lim_ot;
  logic [COUNT_W-1:0]     lim_retry;

  int failures = 0;
  int reports_sent = 0;
  int summaries_checked = 0;
  logic [FAULT_W-1:0] faults_seen = '0;

  slave_report_t next_report;
  slave_report_t taken_report;
  scan_summary_t want;
  bit            in_taken = 1'b0;
  int            burst_left = 4;
  int            idle_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            stall_left = 0;

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [17:0] exp_val,
                             input logic [17:0] got_val);
    if (got_val !== exp_val)
      report_failure($sformatf("%s expected %0h, got %0h", name, exp_val, got_val));
  endtask

  function automatic void clear_scan_totals();
    acc_min_v     = FULL_SCALE_16;
    acc_max_v     = '0;
    acc_max_t     = '0;
    acc_temp_sum  = '0;
    acc_stack_sum = '0;
  endfunction

  // step up on a crossing, down otherwise; reaching the retry limit latches
  function automatic void bump_fault(input int idx, input bit crossed);
    int c;
    c = fault_count[idx] + (crossed ? 1 : -1);
    if (c >= int'(lim_retry)) begin
      c = int'(lim_retry);
      fault_latch[idx] = 1'b1;
    end else if (c < 0) begin
      c = 0;
    end
    fault_count[idx] = c;
  endfunction

  function automatic void fold_report(input slave_report_t r);
    int            tsum;
    int            ssum;
    int            avg;
    scan_summary_t s;
    if (r.cell_min < acc_min_v) acc_min_v = r.cell_min;
    if (r.cell_max > acc_max_v) acc_max_v = r.cell_max;
    tsum = int'(acc_temp_sum);
    for (int j = 0; j < THERMISTOR_COUNT; j++) begin
      if (r.temps[j] > acc_max_t) acc_max_t = r.temps[j];
      tsum += int'(r.temps[j]);
      if (tsum > int'(TEMP_SUM_MAX)) tsum = int'(TEMP_SUM_MAX);
    end
    acc_temp_sum = tsum[TEMP_SUM_W-1:0];
    ssum = int'(acc_stack_sum) + int'(r.stack);
    if (ssum > int'(STACK_SUM_MAX)) ssum = int'(STACK_SUM_MAX);
    acc_stack_sum = ssum[STACK_SUM_W-1:0];
    if (!r.last) return;

    bump_fault(FAULT_OV, acc_max_v > lim_ov);
    bump_fault(FAULT_UV, acc_min_v < lim_uv);
    bump_fault(FAULT_OT, acc_max_t > lim_ot);

    // divisor is fixed even when the scan had a different number of slaves
    avg = int'(acc_temp_sum) / (SLAVE_COUNT * THERMISTOR_COUNT);
    if (avg > 65535) avg = 65535;
    s.max_v    = acc_max_v;
    s.min_v    = acc_min_v;
    s.spread   = acc_max_v - acc_min_v;
    s.max_t    = acc_max_t;
    s.avg_t    = avg[15:0];
    s.trac     = 18'(int'(acc_stack_sum) / PARALLEL_STRINGS);
    s.faults   = fault_latch;
    s.shutdown = |fault_latch;
    pending_summaries.push_back(s);
    clear_scan_totals();
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic slave_report_t make_report(input report_style_t style);
    slave_report_t r;
    r.last = 1'b0;
    case (style)
      CELLS_NOMINAL: begin
        r.cell_min = 16'($urandom_range(2600, 4000));
        r.cell_max = r.cell_min + 16'($urandom_range(0, 400));
        for (int j = 0; j < THERMISTOR_COUNT; j++)
          r.temps[j] = 16'($urandom_range(10000, 45000));
        r.stack = 16'($urandom_range(30000, 60000));
      end
      CELLS_ANY: begin
        r.cell_min = 16'($urandom);
        r.cell_max = 16'($urandom);
        for (int j = 0; j < THERMISTOR_COUNT; j++) r.temps[j] = 16'($urandom);
        r.stack = 16'($urandom);
      end
      default: begin
        r.cell_min = pick_extreme();
        r.cell_max = pick_extreme();
        for (int j = 0; j < THERMISTOR_COUNT; j++) r.temps[j] = pick_extreme();
        r.stack = pick_extreme();
      end
    endcase
    return r;
  endfunction

  function automatic slave_report_t uniform_report(input logic [15:0] vmin, vmax, temp,
                                                   stack, input logic last);
    slave_report_t r;
    r.cell_min = vmin;
    r.cell_max = vmax;
    for (int j = 0; j < THERMISTOR_COUNT; j++) r.temps[j] = temp;
    r.stack = stack;
    r.last  = last;
    return r;
  endfunction

  // mostly full scans, some short or long ones, a little noise inside each
  task automatic add_random_scans(input int n_items);
    int            added;
    int            len;
    report_style_t style;
    slave_report_t r;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(0, 4) < 3) ? SLAVE_COUNT : $urandom_range(1, 9);
      case ($urandom_range(0, 9))
        0:       style = CELLS_EXTREME;
        1, 2:    style = CELLS_ANY;
        default: style = CELLS_NOMINAL;
      endcase
      for (int k = 0; k < len; k++) begin
        r      = make_report(($urandom_range(0, 9) == 0) ? CELLS_ANY : style);
        r.last = (k == len - 1);
        queued_reports.push_back(r);
      end
      added += len;
    end
  endtask

  // limits only change with the pipe empty
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_reports.size() != 0 || in_valid || pending_summaries.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_limits(input logic [15:0] ov, uv, ot, input logic [6:0] retry);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_OVER_VOLTAGE;
    wr_data  <= ov;
    @(negedge clk);
    wr_index <= REG_UNDER_VOLTAGE;
    wr_data  <= uv;
    @(negedge clk);
    wr_index <= REG_OVER_TEMP;
    wr_data  <= ot;
    @(negedge clk);
    wr_index <= REG_RETRY;
    wr_data  <= {9'($urandom), retry};
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (queued_reports.size() > 0) begin
        next_report = queued_reports.pop_front();
        slave_min_voltage <= next_report.cell_min;
        slave_max_voltage <= next_report.cell_max;
        temp_reading_0    <= next_report.temps[0];
        temp_reading_1    <= next_report.temps[1];
        temp_reading_2    <= next_report.temps[2];
        temp_reading_3    <= next_report.temps[3];
        temp_reading_4    <= next_report.temps[4];
        stack_voltage     <= next_report.stack;
        last_slave        <= next_report.last;
        in_valid          <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          idle_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                   : $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, changes mode at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // sample both channels and the write port, predict and check
  always @(posedge clk) begin
    if (rst) begin
      in_taken  = 1'b0;
      lim_ov    = OV_LIMIT_RESET;
      lim_uv    = UV_LIMIT_RESET;
      lim_ot    = OT_LIMIT_RESET;
      lim_retry = RETRY_LIMIT_RESET;
      clear_scan_totals();
      for (int i = 0; i < FAULT_W; i++) fault_count[i] = 0;
      fault_latch = '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_OVER_VOLTAGE:  lim_ov    = wr_data;
          REG_UNDER_VOLTAGE: lim_uv    = wr_data;
          REG_OVER_TEMP:     lim_ot    = wr_data;
          REG_RETRY:         lim_retry = wr_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        taken_report.cell_min = slave_min_voltage;
        taken_report.cell_max = slave_max_voltage;
        taken_report.temps[0] = temp_reading_0;
        taken_report.temps[1] = temp_reading_1;
        taken_report.temps[2] = temp_reading_2;
        taken_report.temps[3] = temp_reading_3;
        taken_report.temps[4] = temp_reading_4;
        taken_report.stack    = stack_voltage;
        taken_report.last     = last_slave;
        reports_sent++;
        fold_report(taken_report);
      end
      if (out_valid && !out_stall) begin
        if (pending_summaries.size() == 0) begin
          report_failure("scan summary with none outstanding");
        end else begin
          want = pending_summaries.pop_front();
          summaries_checked++;
          faults_seen |= fault_bits;
          check_field("pack_max_voltage", want.max_v, pack_max_voltage);
          check_field("pack_min_voltage", want.min_v, pack_min_voltage);
          check_field("voltage_spread", want.spread, voltage_spread);
          check_field("pack_max_temp", want.max_t, pack_max_temp);
          check_field("pack_avg_temp", want.avg_t, pack_avg_temp);
          check_field("tractive_voltage", want.trac, tractive_voltage);
          check_field("fault_bits", want.faults, fault_bits);
          check_field("shutdown", want.shutdown, shutdown);
        end
      end
    end
  end

  initial begin
    slave_report_t r;
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = REG_OVER_VOLTAGE;
    wr_data           = '0;
    in_valid          = 1'b0;
    out_stall         = 1'b0;
    slave_min_voltage = '0;
    slave_max_voltage = '0;
    temp_reading_0    = '0;
    temp_reading_1    = '0;
    temp_reading_2    = '0;
    temp_reading_3    = '0;
    temp_reading_4    = '0;
    stack_voltage     = '0;
    last_slave        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed scans under the reset limits
    queued_reports.push_back(uniform_report(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    queued_reports.push_back(uniform_report(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // seven full-scale slaves: both sums and the average saturate
    for (int k = 0; k < 7; k++)
      queued_reports.push_back(uniform_report(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                              k == 6));
    // hottest reading moves through every thermistor position
    for (int k = 0; k < THERMISTOR_COUNT; k++) begin
      r = uniform_report(16'(3000 + k * 10), 16'(3500 + k * 10), 16'd200, 16'd20000,
                         k == THERMISTOR_COUNT - 1);
      r.temps[k] = 16'(60000 + k);
      queued_reports.push_back(r);
    end
    // min above max: spread wraps
    queued_reports.push_back(uniform_report(16'd5000, 16'd100, 16'd300, 16'd1000, 1'b0));
    queued_reports.push_back(uniform_report(16'd4000, 16'd200, 16'd300, 16'd1000, 1'b1));
    queued_reports.push_back(uniform_report(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    for (int k = 0; k < SLAVE_COUNT; k++) begin
      r      = make_report(CELLS_NOMINAL);
      r.last = (k == SLAVE_COUNT - 1);
      queued_reports.push_back(r);
    end
    wait_drained();

    load_limits(16'd4100, 16'd3000, 16'd42000, 7'd127);
    add_random_scans(90);
    wait_drained();
    // lowered retry limit with counters possibly above it
    load_limits(16'($urandom_range(3600, 4300)), 16'($urandom_range(2600, 3300)),
                16'($urandom_range(30000, 45000)), 7'd5);
    add_random_scans(90);
    wait_drained();
    load_limits(16'hFFFF, 16'h0000, 16'hFFFF, 7'd1);
    add_random_scans(60);
    wait_drained();
    load_limits(16'h0000, 16'hFFFF, 16'h0000, 7'd127);
    add_random_scans(60);
    wait_drained();
    // retry limit zero latches on the first crossing
    load_limits(16'($urandom_range(3600, 4300)), 16'($urandom_range(2600, 3300)),
                16'($urandom_range(30000, 45000)), 7'd0);
    add_random_scans(80);
    wait_drained();
    for (int p = 0; p < 3; p++) begin
      load_limits(16'($urandom), 16'($urandom), 16'($urandom),
                  7'($urandom_range(1, 127)));
      add_random_scans(80);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (pending_summaries.size() != 0)
      report_failure($sformatf("%0d scan summaries never arrived",
                               pending_summaries.size()));
    $display("%0d slave reports sent over nine limit settings, %0d scan summaries checked",
             reports_sent, summaries_checked);
    $display("fault bits observed latched: %b, %0d failures", faults_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the scan pipe to drain");
    $display("Test completed with failures");
    $finish;
  end

endmodule
